FILE: hw/rtl/wc3_pkg.sv
`timescale 1ns / 1ps

package wc3_pkg;

  localparam int CH_W           = 16;
  localparam int PIX_W          = 3 * CH_W;
  localparam int TAPS           = 9;
  localparam int GAIN_W         = 16;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int MAX_HEIGHT     = 4096;
  localparam int IMG_W_W        = 12;
  localparam int IMG_H_W        = 13;
  localparam int ROW_W          = 12;
  localparam int CFG_IDX_W      = 3;
  localparam int GREY_BITS      = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GREY_MODE   = 3'd0,
    CFG_KERN_TOP    = 3'd1,
    CFG_KERN_MIDDLE = 3'd2,
    CFG_KERN_BOTTOM = 3'd3,
    CFG_GREY_GAIN   = 3'd4,
    CFG_IMG_WIDTH   = 3'd5,
    CFG_IMG_HEIGHT  = 3'd6
  } cfg_idx_t;

  typedef logic [TAPS-1:0][PIX_W-1:0] win_t;
  typedef logic [TAPS-1:0][CH_W-1:0]  coeff_t;

  typedef struct packed {
    logic              grey_mode;
    logic [GAIN_W-1:0] gain;
  } mac_cfg_t;

  typedef struct packed {
    logic signed [CH_W-1:0] blue;
    logic signed [CH_W-1:0] green;
    logic signed [CH_W-1:0] red;
  } mac_res_t;

endpackage

FILE: hw/rtl/wc3_line_mem.sv
`timescale 1ns / 1ps

module wc3_line_mem #(
  parameter int DEPTH = 2048,
  parameter int DW    = 96
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/wc3_mac.sv
`timescale 1ns / 1ps

module wc3_mac #(
  parameter int COEFF_FRAC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  wc3_pkg::win_t       win,
  input  wc3_pkg::coeff_t     coeff,
  input  wc3_pkg::mac_cfg_t   cfg,
  output logic                done,
  output wc3_pkg::mac_res_t   res
);
  import wc3_pkg::*;

  localparam int PROD_W  = CH_W + 1 + CH_W;
  localparam int ACC_W   = PROD_W + 4;
  localparam int GACC_W  = 28;
  localparam int GPROD_W = GACC_W + GAIN_W + 1;
  localparam int GSHIFT  = COEFF_FRAC_BITS + GAIN_FRAC_BITS;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_RUN  = 4'b0010,
    M_GAIN = 4'b0100,
    M_GFIN = 4'b1000
  } mstate_t;

  mstate_t                    state_r, state_nxt;
  logic [3:0]                 tap_r, tap_nxt;
  logic [1:0]                 ch_r, ch_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [GPROD_W-1:0]  gprod_r, gprod_nxt;
  logic                       done_r, done_nxt;
  mac_res_t                   res_r, res_nxt;

  logic [PIX_W-1:0]           pix_sel;
  logic signed [CH_W-1:0]     coeff_sel;
  logic signed [CH_W:0]       val;
  logic signed [ACC_W-1:0]    acc_fin;
  logic signed [ACC_W:0]      acc_adj;
  logic signed [ACC_W:0]      acc_q;
  logic signed [GPROD_W:0]    g_adj;
  logic signed [GPROD_W:0]    g_q;
  logic signed [CH_W-1:0]     rgb_sat;
  logic signed [CH_W-1:0]     grey_sat;

  always_comb begin
    pix_sel   = '0;
    coeff_sel = '0;
    for (int i = 0; i < TAPS; i++) begin
      if (tap_r == 4'(i)) begin
        pix_sel   = win[i];
        coeff_sel = coeff[i];
      end
    end
  end

  always_comb begin
    if (cfg.grey_mode) begin
      val = $signed({{(CH_W + 1 - GREY_BITS){1'b0}}, pix_sel[GREY_BITS-1:0]});
    end else begin
      case (ch_r)
        2'd1:    val = {pix_sel[2*CH_W-1], pix_sel[2*CH_W-1:CH_W]};
        2'd2:    val = {pix_sel[3*CH_W-1], pix_sel[3*CH_W-1:2*CH_W]};
        default: val = {pix_sel[CH_W-1], pix_sel[CH_W-1:0]};
      endcase
    end
  end

  // truncate toward zero, then saturate
  always_comb begin
    acc_fin = acc_r + ACC_W'(prod_r);
    acc_adj = (ACC_W + 1)'(acc_fin);
    if (acc_fin < 0) begin
      acc_adj = acc_adj + (ACC_W + 1)'((1 << COEFF_FRAC_BITS) - 1);
    end
    acc_q = acc_adj >>> COEFF_FRAC_BITS;
    if (acc_q > (ACC_W + 1)'(32767)) begin
      rgb_sat = 16'sh7fff;
    end else if (acc_q < -(ACC_W + 1)'(32768)) begin
      rgb_sat = -16'sh8000;
    end else begin
      rgb_sat = acc_q[CH_W-1:0];
    end
  end

  always_comb begin
    g_adj = (GPROD_W + 1)'(gprod_r);
    if (gprod_r < 0) begin
      g_adj = g_adj + (GPROD_W + 1)'((64'd1 << GSHIFT) - 64'd1);
    end
    g_q = g_adj >>> GSHIFT;
    if (g_q > (GPROD_W + 1)'(32767)) begin
      grey_sat = 16'sh7fff;
    end else if (g_q < -(GPROD_W + 1)'(32768)) begin
      grey_sat = -16'sh8000;
    end else begin
      grey_sat = g_q[CH_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    ch_nxt    = ch_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    gprod_nxt = gprod_r;
    done_nxt  = done_r;
    res_nxt   = res_r;
    unique case (state_r)
      M_IDLE: begin
        if (start) begin
          state_nxt = M_RUN;
          tap_nxt   = '0;
          ch_nxt    = '0;
          acc_nxt   = '0;
          done_nxt  = 1'b0;
        end
      end
      M_RUN: begin
        if (tap_r < 4'(TAPS)) begin
          prod_nxt = val * coeff_sel;
          if (tap_r != 4'd0) begin
            acc_nxt = acc_r + ACC_W'(prod_r);
          end
          tap_nxt = tap_r + 4'd1;
        end else begin
          acc_nxt = acc_fin;
          tap_nxt = '0;
          if (cfg.grey_mode) begin
            state_nxt = M_GAIN;
          end else begin
            case (ch_r)
              2'd0:    res_nxt.blue  = rgb_sat;
              2'd1:    res_nxt.green = rgb_sat;
              default: res_nxt.red   = rgb_sat;
            endcase
            if (ch_r == 2'd2) begin
              state_nxt = M_IDLE;
              done_nxt  = 1'b1;
            end else begin
              ch_nxt  = ch_r + 2'd1;
              acc_nxt = '0;
            end
          end
        end
      end
      M_GAIN: begin
        // grey accumulator fits 28 bits: nine taps of 255 times 16-bit coefficients
        gprod_nxt = $signed(acc_r[GACC_W-1:0]) * $signed({1'b0, cfg.gain});
        state_nxt = M_GFIN;
      end
      M_GFIN: begin
        res_nxt.blue  = grey_sat;
        res_nxt.green = '0;
        res_nxt.red   = '0;
        done_nxt      = 1'b1;
        state_nxt     = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      tap_r   <= '0;
      ch_r    <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      ch_r    <= ch_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    gprod_r <= gprod_nxt;
    res_r   <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == M_IDLE)
    else $error("filter started while busy");
  a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(state_r == M_RUN || state_r == M_GFIN))
    else $error("done raised without finishing a channel");
  a_grey_path: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == M_GAIN |=> state_r == M_GFIN)
    else $error("gain stage not followed by rounding");
`endif

endmodule

FILE: hw/rtl/window_convolution_3x3.sv
`timescale 1ns / 1ps

// 3x3 convolution over a raster pixel stream, three signed 16-bit channels or
// one 8-bit grey channel with gain. The two previous rows live in one line
// memory (one word per column holding both rows); a 3x3 window of flip-flops
// slides along the row. A pixel is taken, and the memory read
// returns in the next cycle, where the window shifts and the line word is written
// back. Border pixels end there. Interior pixels then go through one
// multiplier shared by all taps and channels, one tap per cycle, plus a gain
// multiply in grey mode; the result is then handed to the output register.
// A finished result waits while the previous one is still held by out_stall.
// The result sits in an output register, so a new pixel is taken while it
// waits. The line memory needs no clearing after reset; out_last marks the
// last interior pixel of a frame.

module window_convolution_3x3 #(
  parameter int KERNEL_SIZE     = 3,
  parameter int MAX_WIDTH       = 2048,
  parameter int COEFF_FRAC_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [wc3_pkg::CH_W-1:0]     in_pixel_blue,
  input  logic signed [wc3_pkg::CH_W-1:0]     in_pixel_green,
  input  logic signed [wc3_pkg::CH_W-1:0]     in_pixel_red,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wc3_pkg::CH_W-1:0]     out_blue,
  output logic signed [wc3_pkg::CH_W-1:0]     out_green,
  output logic signed [wc3_pkg::CH_W-1:0]     out_red,
  output logic                                out_last,
  input  logic                                cfg_wr_en,
  input  logic [wc3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wc3_pkg::PIX_W-1:0]           cfg_wdata
);
  import wc3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;
  localparam int WW = (CW > IMG_W_W) ? CW : IMG_W_W;
  localparam int KS = KERNEL_SIZE;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SHIFT = 3'b010,
    S_CALC  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic                  grey_mode_r;
  logic [PIX_W-1:0]      kern_r [KS];
  logic [GAIN_W-1:0]     gain_r;
  logic [IMG_W_W-1:0]    img_w_r;
  logic [IMG_H_W-1:0]    img_h_r;

  logic [AW-1:0]         col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [PIX_W-1:0]      pix_r;
  logic [PIX_W-1:0]      win_r [KS][KS];
  logic                  last_r, last_nxt;

  logic                  out_valid_r;
  logic signed [CH_W-1:0] out_blue_r, out_green_r, out_red_r;
  logic                  out_last_r;

  logic                  in_acc;
  logic [2*PIX_W-1:0]    rd_data;
  logic [PIX_W-1:0]      older, newer;
  logic                  mem_wr;
  logic [WW-1:0]         w_ext, w_eff, col_inc;
  logic [IMG_H_W-1:0]    h_eff, row_inc;
  logic                  emit;
  logic                  mac_start, mac_done, out_load;
  win_t                  win_flat;
  coeff_t                coeff_flat;
  mac_cfg_t              mac_cfg;
  mac_res_t              mac_res;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grey_mode_r <= 1'b0;
      kern_r[0]   <= '0;
      kern_r[1]   <= PIX_W'(1 << COEFF_FRAC_BITS);
      kern_r[2]   <= '0;
      gain_r      <= GAIN_W'(1 << GAIN_FRAC_BITS);
      img_w_r     <= IMG_W_W'(640);
      img_h_r     <= IMG_H_W'(480);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GREY_MODE:   grey_mode_r <= cfg_wdata[0];
        CFG_KERN_TOP:    kern_r[0]   <= cfg_wdata;
        CFG_KERN_MIDDLE: kern_r[1]   <= cfg_wdata;
        CFG_KERN_BOTTOM: kern_r[2]   <= cfg_wdata;
        CFG_GREY_GAIN:   gain_r      <= cfg_wdata[GAIN_W-1:0];
        CFG_IMG_WIDTH:   img_w_r     <= cfg_wdata[IMG_W_W-1:0];
        CFG_IMG_HEIGHT:  img_h_r     <= cfg_wdata[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  wc3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * PIX_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (mem_wr),
    .wr_addr (col_r),
    .wr_data ({newer, pix_r})
  );

  assign older  = rd_data[2*PIX_W-1:PIX_W];
  assign newer  = rd_data[PIX_W-1:0];
  assign mem_wr = (state_r == S_SHIFT);

  // effective frame size, clamped to the legal range
  always_comb begin
    w_ext = WW'(img_w_r);
    if (w_ext < WW'(3)) begin
      w_eff = WW'(3);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (img_h_r < IMG_H_W'(3)) begin
      h_eff = IMG_H_W'(3);
    end else if (img_h_r > IMG_H_W'(MAX_HEIGHT)) begin
      h_eff = IMG_H_W'(MAX_HEIGHT);
    end else begin
      h_eff = img_h_r;
    end
    col_inc = WW'(col_r) + WW'(1);
    row_inc = IMG_H_W'(row_r) + IMG_H_W'(1);
    emit    = (row_r >= ROW_W'(2)) && (col_r >= AW'(2));
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    last_nxt = last_r;
    if (state_r == S_SHIFT) begin
      last_nxt = (IMG_H_W'(row_r) == h_eff - IMG_H_W'(1)) && (WW'(col_r) == w_eff - WW'(1));
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[AW-1:0];
      end
    end
  end

  assign mac_start = (state_r == S_SHIFT) && emit;
  assign out_load  = (state_r == S_CALC) && mac_done && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_SHIFT;
      S_SHIFT: state_nxt = emit ? S_CALC : S_IDLE;
      S_CALC:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < KS; r++) begin
        for (int s = 0; s < KS; s++) begin
          win_r[r][s] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      last_r  <= last_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_SHIFT) begin
        for (int r = 0; r < KS; r++) begin
          for (int s = 0; s < KS - 1; s++) begin
            win_r[r][s] <= win_r[r][s+1];
          end
        end
        win_r[0][KS-1] <= older;
        win_r[1][KS-1] <= newer;
        win_r[2][KS-1] <= pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r <= {in_pixel_red, in_pixel_green, in_pixel_blue};
    end
    if (out_load) begin
      out_blue_r  <= mac_res.blue;
      out_green_r <= mac_res.green;
      out_red_r   <= mac_res.red;
      out_last_r  <= last_r;
    end
  end

  always_comb begin
    for (int r = 0; r < KS; r++) begin
      for (int s = 0; s < KS; s++) begin
        win_flat[r*KS+s]   = win_r[r][s];
        coeff_flat[r*KS+s] = kern_r[r][s*CH_W +: CH_W];
      end
    end
    mac_cfg.grey_mode = grey_mode_r;
    mac_cfg.gain      = gain_r;
  end

  wc3_mac #(
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .win   (win_flat),
    .coeff (coeff_flat),
    .cfg   (mac_cfg),
    .done  (mac_done),
    .res   (mac_res)
  );

  assign out_valid = out_valid_r;
  assign out_blue  = out_blue_r;
  assign out_green = out_green_r;
  assign out_red   = out_red_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  a_shift_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> $past(in_valid && !in_stall))
    else $error("window shift without an accepted request");
  a_result_from_filter: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_CALC && mac_done))
    else $error("result shown without a finished filter");
  a_no_start_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    mac_start |=> state_r == S_CALC && !mac_done)
    else $error("filter start did not enter calc");
`endif

endmodule

FILE: tb/sv/window_convolution_3x3_tb.sv
`timescale 1ns / 1ps

module window_convolution_3x3_tb;
  import wc3_pkg::*;

  localparam int MAX_W        = 2048;
  localparam int FRAC_BITS    = 10;
  localparam int IDLE_LIMIT   = 5000;
  localparam int SETTLE_CYC   = 60;
  localparam int TARGET_ITEMS = 1050;
  localparam int WIDE_PIXELS  = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

  typedef struct {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic            last;
  } filtered_px_t;

  class conv_scoreboard;
    logic              grey_mode;
    logic [PIX_W-1:0]  kern [3];
    logic [GAIN_W-1:0] gain;
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [PIX_W-1:0]  lines [2*MAX_W];
    logic [PIX_W-1:0]  win [3][3];
    int                col;
    int                row;
    filtered_px_t      pending_px[$];
    int                errors;

    function new();
      grey_mode  = 0;
      kern[0]    = 0;
      kern[1]    = 48'd1024;
      kern[2]    = 0;
      gain       = 16'd4096;
      width_reg  = IMG_W_W'(640);
      height_reg = IMG_H_W'(480);
      foreach (lines[i]) lines[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      col = 0;
      row = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] val);
      case (idx)
        CFG_GREY_MODE:   grey_mode  = val[0];
        CFG_KERN_TOP:    kern[0]    = val;
        CFG_KERN_MIDDLE: kern[1]    = val;
        CFG_KERN_BOTTOM: kern[2]    = val;
        CFG_GREY_GAIN:   gain       = val[GAIN_W-1:0];
        CFG_IMG_WIDTH:   width_reg  = val[IMG_W_W-1:0];
        CFG_IMG_HEIGHT:  height_reg = val[IMG_H_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CH_W-1:0] clip16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[CH_W-1:0];
    endfunction

    function longint tap_sum(int ch, bit grey);
      longint acc;
      longint cf;
      longint pv;
      logic [CH_W-1:0] raw;
      acc = 0;
      for (int r = 0; r < 3; r++) begin
        for (int s = 0; s < 3; s++) begin
          raw = kern[r][16*s +: 16];
          cf  = longint'($signed(raw));
          if (grey) begin
            pv = longint'({1'b0, win[r][s][7:0]});
          end else begin
            raw = win[r][s][16*ch +: 16];
            pv  = longint'($signed(raw));
          end
          acc += pv * cf;
        end
      end
      return acc;
    endfunction

    function void note_pixel(logic [CH_W-1:0] b, logic [CH_W-1:0] g, logic [CH_W-1:0] r);
      int w;
      int h;
      int c;
      logic [PIX_W-1:0] pix;
      logic [PIX_W-1:0] older;
      logic [PIX_W-1:0] newer;
      filtered_px_t px;
      w = width_reg;
      h = height_reg;
      if (w < 3) w = 3;
      if (w > MAX_W) w = MAX_W;
      if (h < 3) h = 3;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      c = col;
      if (c >= MAX_W) c = 0;
      pix   = {r, g, b};
      older = lines[c];
      newer = lines[MAX_W + c];
      lines[c] = newer;
      lines[MAX_W + c] = pix;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = older;
      win[1][2] = newer;
      win[2][2] = pix;
      if (row >= 2 && c >= 2) begin
        if (grey_mode) begin
          px.blue  = clip16((tap_sum(0, 1) * longint'(gain)) /
                            (longint'(1) << (FRAC_BITS + GAIN_FRAC_BITS)));
          px.green = '0;
          px.red   = '0;
        end else begin
          px.blue  = clip16(tap_sum(0, 0) / (longint'(1) << FRAC_BITS));
          px.green = clip16(tap_sum(1, 0) / (longint'(1) << FRAC_BITS));
          px.red   = clip16(tap_sum(2, 0) / (longint'(1) << FRAC_BITS));
        end
        px.last = (row == h - 1 && c == w - 1);
        pending_px = {pending_px, px};
      end
      c++;
      if (c >= w) begin
        c = 0;
        row++;
        if (row >= h) row = 0;
      end
      col = c;
    endfunction

    function void check_pixel(logic [CH_W-1:0] b, logic [CH_W-1:0] g, logic [CH_W-1:0] r,
                              logic last);
      filtered_px_t px;
      if (pending_px.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result b=%h g=%h r=%h last=%b", b, g, r, last);
        return;
      end
      px = pending_px.pop_front();
      if (px.blue !== b || px.green !== g || px.red !== r || px.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected b=%h g=%h r=%h last=%b, got b=%h g=%h r=%h last=%b",
                   px.blue, px.green, px.red, px.last, b, g, r, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [CH_W-1:0] in_pixel_blue;
  logic signed [CH_W-1:0] in_pixel_green;
  logic signed [CH_W-1:0] in_pixel_red;
  logic out_valid;
  logic out_stall;
  logic signed [CH_W-1:0] out_blue;
  logic signed [CH_W-1:0] out_green;
  logic signed [CH_W-1:0] out_red;
  logic out_last;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PIX_W-1:0] cfg_wdata;

  conv_scoreboard sb = new();
  bit calm;
  int idle_cycles;
  int sent;

  window_convolution_3x3 dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_blue(in_pixel_blue), .in_pixel_green(in_pixel_green),
    .in_pixel_red(in_pixel_red),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red), .out_last(out_last),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // result side: check and stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_pixel(out_blue, out_green, out_red, out_last);
    out_stall <= (!calm && $urandom_range(99) < 19);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_pixel(logic [CH_W-1:0] b, logic [CH_W-1:0] g, logic [CH_W-1:0] r);
    in_valid       <= 1'b1;
    in_pixel_blue  <= b;
    in_pixel_green <= g;
    in_pixel_red   <= r;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(b, g, r);
    sent++;
    if (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [CH_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h00ff;
      default: return CH_W'($urandom());
    endcase
  endfunction

  task automatic send_random();
    send_pixel(rand_sample(), rand_sample(), rand_sample());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    // border requests leave no result but may still be in flight
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic end_cfg();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] rand_kernel_row();
    logic [PIX_W-1:0] k;
    k = PIX_W'({$urandom(), $urandom()});
    if ($urandom_range(2) != 0)
      for (int s = 0; s < 3; s++) k[16*s +: 16] = 16'($urandom_range(0, 2048) - 1024);
    return k;
  endfunction

  function automatic logic [PIX_W-1:0] rand_width();
    case ($urandom_range(9))
      0: return PIX_W'($urandom_range(0, 2));
      1: return PIX_W'($urandom_range(9, 16));
      default: return PIX_W'($urandom_range(3, 8));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_height();
    if ($urandom_range(5) == 0) return PIX_W'($urandom_range(0, 2));
    return PIX_W'($urandom_range(3, 6));
  endfunction

  initial begin
    logic [CH_W-1:0] extremes [6];
    int phase;
    extremes = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h00ff};
    calm = 0;
    sent = 0;
    rst_n = 0;
    in_valid = 0;
    in_pixel_blue = 0;
    in_pixel_green = 0;
    in_pixel_red = 0;
    out_stall = 0;
    cfg_wr_en = 0;
    cfg_index = CFG_GREY_MODE;
    cfg_wdata = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extreme coefficients so blue and red saturate both ways and green saturates high
    write_reg(CFG_IMG_WIDTH, 48'd5);
    write_reg(CFG_IMG_HEIGHT, 48'd3);
    write_reg(CFG_KERN_TOP, 48'h8000_8000_8000);
    write_reg(CFG_KERN_MIDDLE, 48'h7fff_0400_7fff);
    write_reg(CFG_NO_REG, 48'hffff_ffff_ffff);
    end_cfg();
    for (int i = 0; i < 15; i++)
      send_pixel(extremes[i % 6], extremes[(i + 2) % 6], extremes[(i + 4) % 6]);
    drain();
    write_reg(CFG_GREY_MODE, 48'd1);
    write_reg(CFG_GREY_GAIN, 48'hffff);
    write_reg(CFG_KERN_BOTTOM, 48'h7fff_7fff_7fff);
    write_reg(CFG_IMG_WIDTH, 48'd0);
    write_reg(CFG_IMG_HEIGHT, 48'd0);
    end_cfg();
    for (int i = 0; i < 9; i++) send_pixel(extremes[i % 6], 16'h1234, 16'hedcb);
    drain();

    phase = 0;
    while (sent < TARGET_ITEMS) begin
      calm = (phase >= 6 && phase < 12);
      // size changes only at frame start, so no unwritten line entry is used
      if ($urandom_range(2) == 0 && !(sb.row == 0 && sb.col == 0)) begin
        while (!(sb.row == 0 && sb.col == 0)) send_random();
      end
      drain();
      if (sb.row == 0 && sb.col == 0) begin
        write_reg(CFG_IMG_WIDTH, rand_width());
        write_reg(CFG_IMG_HEIGHT, rand_height());
      end
      write_reg(CFG_GREY_MODE, PIX_W'($urandom_range(1)));
      write_reg(CFG_KERN_TOP, rand_kernel_row());
      write_reg(CFG_KERN_MIDDLE, rand_kernel_row());
      write_reg(CFG_KERN_BOTTOM, rand_kernel_row());
      write_reg(CFG_GREY_GAIN,
                ($urandom_range(3) == 0) ? 48'hffff : PIX_W'($urandom_range(0, 8192)));
      end_cfg();
      repeat ($urandom_range(10, 60)) send_random();
      phase++;
    end

    // very tall frame cut short by a smaller height mid-frame
    while (!(sb.row == 0 && sb.col == 0)) send_random();
    drain();
    write_reg(CFG_IMG_WIDTH, 48'd4);
    write_reg(CFG_IMG_HEIGHT, 48'h1fff);
    end_cfg();
    repeat (48) send_random();
    drain();
    write_reg(CFG_IMG_HEIGHT, 48'd3);
    end_cfg();
    while (!(sb.row == 0 && sb.col == 0)) send_random();

    // widest row setting, narrowed partway through the first row
    drain();
    write_reg(CFG_GREY_MODE, 48'd0);
    write_reg(CFG_IMG_WIDTH, 48'hfff);
    write_reg(CFG_IMG_HEIGHT, 48'd3);
    end_cfg();
    repeat (WIDE_PIXELS) send_random();
    drain();
    write_reg(CFG_IMG_WIDTH, 48'd4);
    end_cfg();
    while (!(sb.row == 0 && sb.col == 0)) send_random();

    drain();
    if (sb.errors == 0 && sb.pending_px.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: window_convolution_3x3.f
hw/rtl/wc3_pkg.sv
hw/rtl/wc3_line_mem.sv
hw/rtl/wc3_mac.sv
hw/rtl/window_convolution_3x3.sv
tb/sv/window_convolution_3x3_tb.sv
